// ===== rtl/wdsc_pkg.sv =====
// ----------------------------------------------------------------------------
// Window deviation stability check - shared package
// Field widths, reset values and the command/status bundles between the
// controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package wdsc_pkg;

   localparam int WINDOW_DEF = 16;

   localparam int COORD_W = 32;
   localparam int DEV_W   = 32;
   localparam int LIMIT_W = 31;
   localparam int MEAN_W  = COORD_W + 1;
   localparam int DIFF_W  = COORD_W + 2;

   localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(100);

   typedef struct packed {
      logic load;
      logic rd_clr;
      logic rd_en;
      logic acc_clr;
      logic pass_dev;
      logic div_start;
      logic div_dev;
      logic mean_load;
      logic rsp_load;
   } wdsc_cmd_type;

   typedef struct packed {
      logic last_rd;
      logic div_done;
   } wdsc_sts_type;

endpackage

`default_nettype wire

// ===== rtl/wdsc_if.sv =====
// ----------------------------------------------------------------------------
// Window deviation stability check - channel interfaces
// Sample, result and register-write channels, each a valid/ready pair
// with its payload.
// ----------------------------------------------------------------------------
`default_nettype none

interface wdsc_req_if;
   logic                                 valid;
   logic                                 ready;
   logic signed [wdsc_pkg::COORD_W-1:0]  coord_first;
   logic signed [wdsc_pkg::COORD_W-1:0]  coord_second;

   modport source (output valid, coord_first, coord_second, input ready);
   modport sink   (input valid, coord_first, coord_second, output ready);
endinterface

interface wdsc_rsp_if;
   logic                          valid;
   logic                          ready;
   logic                          stable;
   logic [wdsc_pkg::DEV_W-1:0]    deviation_first;
   logic [wdsc_pkg::DEV_W-1:0]    deviation_second;

   modport source (output valid, stable, deviation_first, deviation_second,
                   input ready);
   modport sink   (input valid, stable, deviation_first, deviation_second,
                   output ready);
endinterface

interface wdsc_csr_if;
   logic                          valid;
   logic                          ready;
   logic [wdsc_pkg::LIMIT_W-1:0]  deviation_limit;

   modport source (output valid, deviation_limit, input ready);
   modport sink   (input valid, deviation_limit, output ready);
endinterface

`default_nettype wire

// ===== rtl/wdsc_div.sv =====
// ----------------------------------------------------------------------------
// Window deviation stability check - unsigned divider
// Restoring divider, one quotient bit per cycle; the quotient holds once
// done has pulsed.
// ----------------------------------------------------------------------------
`default_nettype none

module wdsc_div #(
   parameter int N_W = 37,
   parameter int D_W = 5
) (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           start,
   input  wire logic [N_W-1:0] dividend,
   input  wire logic [D_W-1:0] divisor,
   output logic                done,
   output logic [N_W-1:0]      quotient
);

   localparam int CW = $clog2(N_W + 1);

   logic           busy_ff;
   logic           done_ff;
   logic [CW-1:0]  cnt_ff;
   logic [N_W-1:0] quo_ff, quo_in;
   logic [D_W-1:0] rem_ff, rem_in;
   logic [D_W-1:0] dvs_ff;
   logic [D_W:0]   shifted;
   logic [D_W:0]   trial;

   always_comb begin
      shifted = {rem_ff, quo_ff[N_W-1]};
      trial   = shifted - {1'b0, dvs_ff};
      if (!trial[D_W]) begin
         rem_in = trial[D_W-1:0];
         quo_in = {quo_ff[N_W-2:0], 1'b1};
      end else begin
         rem_in = shifted[D_W-1:0];
         quo_in = {quo_ff[N_W-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CW'(N_W);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - CW'(1);
            if (cnt_ff == CW'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff <= dividend;
         rem_ff <= '0;
         dvs_ff <= divisor;
      end else if (busy_ff) begin
         quo_ff <= quo_in;
         rem_ff <= rem_in;
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

`default_nettype wire

// ===== rtl/wdsc_dp.sv =====
// ----------------------------------------------------------------------------
// Window deviation stability check - datapath
// Sample windows, read pointer, per-axis accumulators, dividers and mean,
// limit register and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module wdsc_dp #(
   parameter int WINDOW = wdsc_pkg::WINDOW_DEF
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire wdsc_pkg::wdsc_cmd_type             cmd,
   output wdsc_pkg::wdsc_sts_type                  sts,
   input  wire logic signed [wdsc_pkg::COORD_W-1:0] coord_first,
   input  wire logic signed [wdsc_pkg::COORD_W-1:0] coord_second,
   input  wire logic                               limit_we,
   input  wire logic [wdsc_pkg::LIMIT_W-1:0]       limit_data,
   output logic                                    stable,
   output logic [wdsc_pkg::DEV_W-1:0]              deviation_first,
   output logic [wdsc_pkg::DEV_W-1:0]              deviation_second
);

   import wdsc_pkg::*;

   localparam int IDX_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
   localparam int CNT_W = $clog2(WINDOW + 1);
   localparam int ACC_W = COORD_W + CNT_W;

   logic [IDX_W-1:0]   wr_slot_ff;
   logic [IDX_W-1:0]   rd_idx_ff;
   logic [CNT_W-1:0]   fill_ff;
   logic               acc_valid_ff;
   logic [LIMIT_W-1:0] limit_ff;
   logic               stable_ff;
   logic [DEV_W-1:0]   dev_first_ff;
   logic [DEV_W-1:0]   dev_second_ff;
   logic [DEV_W-1:0]   dev_q [2];
   logic [1:0]         div_done;
   logic               stable_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_slot_ff   <= '0;
         fill_ff      <= '0;
         rd_idx_ff    <= '0;
         acc_valid_ff <= 1'b0;
         limit_ff     <= LIMIT_RESET;
      end else begin
         if (limit_we) begin
            limit_ff <= limit_data;
         end
         if (cmd.load) begin
            if (wr_slot_ff == IDX_W'(WINDOW - 1)) begin
               wr_slot_ff <= '0;
            end else begin
               wr_slot_ff <= wr_slot_ff + IDX_W'(1);
            end
            if (fill_ff != CNT_W'(WINDOW)) begin
               fill_ff <= fill_ff + CNT_W'(1);
            end
         end
         if (cmd.rd_clr) begin
            rd_idx_ff <= '0;
         end else if (cmd.rd_en) begin
            rd_idx_ff <= rd_idx_ff + IDX_W'(1);
         end
         acc_valid_ff <= cmd.rd_en;
      end
   end

   assign sts.last_rd  = ((CNT_W'(rd_idx_ff) + CNT_W'(1)) == fill_ff);
   assign sts.div_done = div_done[0] & div_done[1];

   for (genvar a = 0; a < 2; a++) begin : g_axis
      logic [COORD_W-1:0]        mem [WINDOW];
      logic signed [COORD_W-1:0] sample;
      logic signed [COORD_W-1:0] rd_data_ff;
      logic signed [ACC_W-1:0]   acc_ff, acc_in;
      logic signed [MEAN_W-1:0]  mean_ff;
      logic [MEAN_W-1:0]         mean_mag;
      logic signed [DIFF_W-1:0]  diff;
      logic [DIFF_W-1:0]         diff_abs;
      logic [ACC_W-1:0]          div_arg;
      logic [ACC_W-1:0]          quo;

      assign sample = (a == 0) ? coord_first : coord_second;

      always_ff @(posedge clock) begin
         if (cmd.load) begin
            mem[wr_slot_ff] <= sample;
         end
         rd_data_ff <= mem[rd_idx_ff];
      end

      always_comb begin
         diff     = DIFF_W'(rd_data_ff) - DIFF_W'(mean_ff);
         diff_abs = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);
         if (cmd.acc_clr) begin
            acc_in = '0;
         end else if (acc_valid_ff) begin
            if (cmd.pass_dev) begin
               acc_in = acc_ff + $signed(ACC_W'(diff_abs));
            end else begin
               acc_in = acc_ff + ACC_W'(rd_data_ff);
            end
         end else begin
            acc_in = acc_ff;
         end
         if (cmd.div_dev) begin
            div_arg = acc_ff;
         end else begin
            div_arg = acc_ff[ACC_W-1] ? ACC_W'(-acc_ff) : ACC_W'(acc_ff);
         end
         mean_mag = {1'b0, quo[COORD_W-1:0]};
      end

      always_ff @(posedge clock) begin
         acc_ff <= acc_in;
         if (cmd.mean_load) begin
            mean_ff <= acc_ff[ACC_W-1] ? -$signed(mean_mag) : $signed(mean_mag);
         end
      end

      wdsc_div #(
         .N_W (ACC_W),
         .D_W (CNT_W)
      ) u_div (
         .clock    (clock),
         .reset    (reset),
         .start    (cmd.div_start),
         .dividend (div_arg),
         .divisor  (fill_ff),
         .done     (div_done[a]),
         .quotient (quo)
      );

      assign dev_q[a] = quo[DEV_W-1:0];
   end

   assign stable_in = (dev_q[0] < {1'b0, limit_ff}) && (dev_q[1] < {1'b0, limit_ff});

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         stable_ff     <= stable_in;
         dev_first_ff  <= dev_q[0];
         dev_second_ff <= dev_q[1];
      end
   end

   assign stable           = stable_ff;
   assign deviation_first  = dev_first_ff;
   assign deviation_second = dev_second_ff;

endmodule

`default_nettype wire

// ===== rtl/wdsc_ctrl.sv =====
// ----------------------------------------------------------------------------
// Window deviation stability check - controller
// Sequences one sample: sum pass, mean division, deviation pass,
// deviation division and hand-off to the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module wdsc_ctrl (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_ready,
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   input  wire wdsc_pkg::wdsc_sts_type sts,
   output wdsc_pkg::wdsc_cmd_type      cmd
);

   import wdsc_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE,
      S_SUM,
      S_SUM_END,
      S_MEAN_GO,
      S_MEAN_WAIT,
      S_DEV,
      S_DEV_END,
      S_DEVD_GO,
      S_DEVD_WAIT,
      S_FIN
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load    = 1'b1;
               cmd.rd_clr  = 1'b1;
               cmd.acc_clr = 1'b1;
               state_in    = S_SUM;
            end
         end
         S_SUM: begin
            cmd.rd_en = 1'b1;
            if (sts.last_rd) begin
               state_in = S_SUM_END;
            end
         end
         S_SUM_END: begin
            state_in = S_MEAN_GO;
         end
         S_MEAN_GO: begin
            cmd.div_start = 1'b1;
            state_in      = S_MEAN_WAIT;
         end
         S_MEAN_WAIT: begin
            if (sts.div_done) begin
               cmd.mean_load = 1'b1;
               cmd.acc_clr   = 1'b1;
               cmd.rd_clr    = 1'b1;
               state_in      = S_DEV;
            end
         end
         S_DEV: begin
            cmd.rd_en    = 1'b1;
            cmd.pass_dev = 1'b1;
            if (sts.last_rd) begin
               state_in = S_DEV_END;
            end
         end
         S_DEV_END: begin
            cmd.pass_dev = 1'b1;
            state_in     = S_DEVD_GO;
         end
         S_DEVD_GO: begin
            cmd.div_start = 1'b1;
            cmd.div_dev   = 1'b1;
            state_in      = S_DEVD_WAIT;
         end
         S_DEVD_WAIT: begin
            cmd.div_dev = 1'b1;
            if (sts.div_done) begin
               state_in = S_FIN;
            end
         end
         S_FIN: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.rsp_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (cmd.rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

// ===== rtl/window_deviation_stability_check_top.sv =====
// ----------------------------------------------------------------------------
// Window deviation stability check - top level
// Sliding-window mean absolute deviation of a two-axis position, with a
// stability flag against a programmable limit.
// ----------------------------------------------------------------------------
// Each accepted beat on req_bus writes one sample into the last-WINDOW
// windows and yields exactly one beat on rsp_bus. With n samples held (up to
// WINDOW), the two passes read the window memories one entry per cycle, and
// the mean and the deviation each go through a one-bit-per-cycle divider.
// Both axes run side by side. One item is worked on at a time; a new sample
// is taken while the previous result still waits in the output register.
// csr_bus is always ready and should be written only while the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module window_deviation_stability_check_top #(
   parameter int WINDOW = wdsc_pkg::WINDOW_DEF
) (
   input  wire logic   clock,
   input  wire logic   reset,
   wdsc_req_if.sink    req_bus,
   wdsc_rsp_if.source  rsp_bus,
   wdsc_csr_if.sink    csr_bus
);

   import wdsc_pkg::*;

   wdsc_cmd_type cmd;
   wdsc_sts_type sts;

   assign csr_bus.ready = 1'b1;

   wdsc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .rsp_valid (rsp_bus.valid),
      .rsp_ready (rsp_bus.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   wdsc_dp #(
      .WINDOW (WINDOW)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .sts              (sts),
      .coord_first      (req_bus.coord_first),
      .coord_second     (req_bus.coord_second),
      .limit_we         (csr_bus.valid),
      .limit_data       (csr_bus.deviation_limit),
      .stable           (rsp_bus.stable),
      .deviation_first  (rsp_bus.deviation_first),
      .deviation_second (rsp_bus.deviation_second)
   );

endmodule

`default_nettype wire

// ===== rtl/wdsc_checker.sv =====
// ----------------------------------------------------------------------------
// Window deviation stability check - port checker
// Watches the top-level channels over time; bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module wdsc_checker (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   input  wire logic                       req_ready,
   input  wire logic                       rsp_valid,
   input  wire logic                       rsp_ready,
   input  wire logic                       stable,
   input  wire logic [wdsc_pkg::DEV_W-1:0] deviation_first,
   input  wire logic [wdsc_pkg::DEV_W-1:0] deviation_second
);

   logic req_beat;

   assign req_beat = req_valid && req_ready;

   a_rsp_hold : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result beat withdrawn before it was taken");

   a_rsp_stable : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=>
         $stable(stable) && $stable(deviation_first) && $stable(deviation_second))
      else $error("result payload changed while stalled");

   a_busy_after_beat : assert property (@(posedge clock) disable iff (reset)
      req_beat |=> !req_ready)
      else $error("sample taken while the previous one is still in work");

   a_no_early_rsp : assert property (@(posedge clock) disable iff (reset)
      req_beat && !rsp_valid |=> !rsp_valid)
      else $error("result appeared in the cycle after its sample");

endmodule

bind window_deviation_stability_check_top wdsc_checker u_wdsc_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_bus.valid),
   .req_ready        (req_bus.ready),
   .rsp_valid        (rsp_bus.valid),
   .rsp_ready        (rsp_bus.ready),
   .stable           (rsp_bus.stable),
   .deviation_first  (rsp_bus.deviation_first),
   .deviation_second (rsp_bus.deviation_second)
);

`default_nettype wire
